FILE: hdl/pdfesc_pkg.sv
`timescale 1ns / 1ps

package pdfesc_pkg;

    localparam int MAX_RESULTS = 6;
    localparam int CNT_W       = 3;
    localparam int IDX_W       = 3;

    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;

    localparam logic [7:0] RAW_NL  = 8'h0A;
    localparam logic [7:0] RAW_CR  = 8'h0D;
    localparam logic [7:0] RAW_TAB = 8'h09;
    localparam logic [7:0] RAW_BS  = 8'h08;
    localparam logic [7:0] RAW_FF  = 8'h0C;

    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_string;
        logic       last_of_string;
        logic       empty_string;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_item;
    } result_t;

    typedef logic [MAX_RESULTS-1:0][7:0] seq_t;

    typedef struct packed {
        seq_t             seq;
        logic [CNT_W-1:0] cnt;
    } expansion_t;

endpackage

FILE: hdl/pdfesc_expand.sv
`timescale 1ns / 1ps

module pdfesc_expand
(
    input  pdfesc_pkg::item_t      item,
    output pdfesc_pkg::expansion_t expansion
);

    logic [7:0]                  code;
    logic [3:0][7:0]             esc;
    logic [pdfesc_pkg::CNT_W-1:0] esc_len;
    logic [7:0]                  c;

    assign c = item.data_byte;

    always_comb
    begin
        case (c)
            pdfesc_pkg::RAW_NL:       code = pdfesc_pkg::CH_N;
            pdfesc_pkg::RAW_CR:       code = pdfesc_pkg::CH_R;
            pdfesc_pkg::RAW_TAB:      code = pdfesc_pkg::CH_T;
            pdfesc_pkg::RAW_BS:       code = pdfesc_pkg::CH_B;
            pdfesc_pkg::RAW_FF:       code = pdfesc_pkg::CH_F;
            pdfesc_pkg::CH_LPAREN:    code = pdfesc_pkg::CH_LPAREN;
            pdfesc_pkg::CH_RPAREN:    code = pdfesc_pkg::CH_RPAREN;
            pdfesc_pkg::CH_BACKSLASH: code = pdfesc_pkg::CH_BACKSLASH;
            default:                  code = 8'h00;
        endcase
    end

    always_comb
    begin
        esc = '0;
        if (code != 8'h00)
        begin
            esc[0]  = pdfesc_pkg::CH_BACKSLASH;
            esc[1]  = code;
            esc_len = pdfesc_pkg::CNT_W'(2);
        end
        else if (c >= pdfesc_pkg::PRINT_LO && c <= pdfesc_pkg::PRINT_HI)
        begin
            esc[0]  = c;
            esc_len = pdfesc_pkg::CNT_W'(1);
        end
        else
        begin
            esc[0]  = pdfesc_pkg::CH_BACKSLASH;
            esc[1]  = pdfesc_pkg::CH_ZERO | {6'b0, c[7:6]};
            esc[2]  = pdfesc_pkg::CH_ZERO | {5'b0, c[5:3]};
            esc[3]  = pdfesc_pkg::CH_ZERO | {5'b0, c[2:0]};
            esc_len = pdfesc_pkg::CNT_W'(4);
        end
    end

    always_comb
    begin
        expansion.seq = '0;
        expansion.cnt = '0;
        if (item.empty_string)
        begin
            expansion.seq[0] = pdfesc_pkg::CH_LPAREN;
            expansion.seq[1] = pdfesc_pkg::CH_RPAREN;
            expansion.cnt    = pdfesc_pkg::CNT_W'(2);
        end
        else
        begin
            if (item.first_of_string)
            begin
                expansion.seq[0] = pdfesc_pkg::CH_LPAREN;
                expansion.seq[1] = esc[0];
                expansion.seq[2] = esc[1];
                expansion.seq[3] = esc[2];
                expansion.seq[4] = esc[3];
                expansion.cnt    = esc_len + pdfesc_pkg::CNT_W'(1);
            end
            else
            begin
                expansion.seq[0] = esc[0];
                expansion.seq[1] = esc[1];
                expansion.seq[2] = esc[2];
                expansion.seq[3] = esc[3];
                expansion.cnt    = esc_len;
            end
            if (item.last_of_string)
            begin
                expansion.seq[expansion.cnt] = pdfesc_pkg::CH_RPAREN;
                expansion.cnt                = expansion.cnt + pdfesc_pkg::CNT_W'(1);
            end
        end
    end

endmodule

FILE: hdl/pdf_literal_string_escape_unit.sv
`timescale 1ns / 1ps

// Escapes one string byte per transfer into PDF literal-string text. A transfer
// is taken when start is high and busy is low; each item yields 1 to 6 output
// bytes, one per cycle on result with strobe high, the final byte of an item
// flagged by last_of_item. The output cannot be stalled: a result is present
// for exactly one cycle. The bytes of an item leave one per cycle, so plain
// bytes inside a string flow at one per cycle, while longer expansions hold
// busy high until the item's final byte is selected. The first output byte
// of an item passes the input expansion register, then the output register.
module pdf_literal_string_escape_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  pdfesc_pkg::item_t   item,
    output logic                strobe,
    output pdfesc_pkg::result_t result
);

    pdfesc_pkg::expansion_t        expansion;
    pdfesc_pkg::expansion_t        exp_reg;
    logic                          valid_reg;
    logic [pdfesc_pkg::IDX_W-1:0]  idx_reg;
    logic [pdfesc_pkg::IDX_W-1:0]  idx_next;
    logic                          valid_next;
    logic                          at_last;
    logic                          take;
    pdfesc_pkg::result_t           result_reg;
    pdfesc_pkg::result_t           result_next;
    logic                          strobe_reg;

    pdfesc_expand u_expand
    (
        .item      (item),
        .expansion (expansion)
    );

    assign at_last = (idx_reg == pdfesc_pkg::IDX_W'(exp_reg.cnt - pdfesc_pkg::CNT_W'(1)));
    assign busy    = valid_reg && !at_last;
    assign take    = start && !busy;

    always_comb
    begin
        result_next.out_byte     = exp_reg.seq[idx_reg];
        result_next.last_of_item = at_last;
        valid_next               = valid_reg && !at_last;
        idx_next                 = idx_reg + pdfesc_pkg::IDX_W'(1);
        if (take)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            strobe_reg <= valid_reg;
            if (valid_reg || take)
            begin
                idx_reg <= idx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            exp_reg <= expansion;
        end
        if (valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    a_take_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> ##2 strobe)
        else $error("transfer did not produce a result");

    a_busy_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> strobe && !result.last_of_item)
        else $error("busy without a pending byte of the same item");

    a_item_continues: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last_of_item |=> strobe)
        else $error("item output broken before its last byte");

endmodule
